/* rtl/core/ott_pkg.sv */
package ott_pkg;

    localparam int unsigned ExpW    = 48;
    localparam int unsigned IdW     = 32;
    localparam int unsigned PeriodW = 32;
    localparam int unsigned SleepW  = 49;

    // Operation codes of an input transaction.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_DEL   = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    // Status codes of a result transaction.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_ACT,
        S_SCAN2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic act;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

    typedef struct packed {
        logic [ExpW-1:0]    expire;
        logic [PeriodW-1:0] period;
        logic [IdW-1:0]     id;
        logic               periodic;
    } t_entry;

    // Expiry time now + period, saturated at the top of the 48-bit range.
    function automatic logic [ExpW-1:0] sat_expiry(input logic [ExpW-1:0] now,
                                                   input logic [PeriodW-1:0] period);
        logic [ExpW:0] sum;
        sum = {1'b0, now} + {{(ExpW + 1 - PeriodW){1'b0}}, period};
        sat_expiry = sum[ExpW] ? {ExpW{1'b1}} : sum[ExpW-1:0];
    endfunction

endpackage

/* rtl/core/ott_ctrl.sv */
module ott_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output ott_pkg::t_cmd o_cmd,
    input  ott_pkg::t_sts i_sts
);

    ott_pkg::t_state r_state;
    ott_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ott_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: scan, act, scan again for the sleep time, report.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ott_pkg::S_IDLE: begin
                if (i_start) n_state = ott_pkg::S_SCAN1;
            end
            ott_pkg::S_SCAN1: begin
                if (i_sts.scan_done) n_state = ott_pkg::S_ACT;
            end
            ott_pkg::S_ACT: begin
                n_state = ott_pkg::S_SCAN2;
            end
            ott_pkg::S_SCAN2: begin
                if (i_sts.scan_done) n_state = ott_pkg::S_DONE;
            end
            ott_pkg::S_DONE: begin
                n_state = ott_pkg::S_IDLE;
            end
            default: begin
                n_state = ott_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.load   = (r_state == ott_pkg::S_IDLE) && i_start;
        o_cmd.act    = (r_state == ott_pkg::S_ACT);
        o_cmd.finish = (r_state == ott_pkg::S_DONE);
        o_busy       = (r_state != ott_pkg::S_IDLE);
    end

    a_act_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.act |-> $past(r_state == ott_pkg::S_SCAN1))
        else $error("act without a completed scan");
    a_finish_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_cmd.finish)
        else $error("finish held for more than one cycle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ott_pkg::S_SCAN1))
        else $error("load did not start a scan");

endmodule

/* rtl/core/ott_dp.sv */
module ott_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ott_pkg::t_cmd                 i_cmd,
    output ott_pkg::t_sts                 o_sts,
    input  logic [1:0]                    i_mode,
    input  logic [ott_pkg::ExpW-1:0]      i_now_ms,
    input  logic [ott_pkg::PeriodW-1:0]   i_period_ms,
    input  logic                          i_periodic,
    input  logic [ott_pkg::IdW-1:0]       i_target_id,
    input  logic [ott_pkg::ExpW-1:0]      i_target_expire,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [ott_pkg::IdW-1:0]       o_timer_id,
    output logic [ott_pkg::ExpW-1:0]      o_expire_ms,
    output logic [ott_pkg::IdW-1:0]       o_rearmed_id,
    output logic signed [ott_pkg::SleepW-1:0] o_sleep_ms
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    ott_pkg::t_entry mem [CAPACITY];

    // Captured transaction.
    logic [1:0]                  r_mode;
    logic [ott_pkg::ExpW-1:0]    r_now;
    logic [ott_pkg::PeriodW-1:0] r_period;
    logic                        r_per;
    logic [ott_pkg::IdW-1:0]     r_tid;
    logic [ott_pkg::ExpW-1:0]    r_texp;

    logic [CAPACITY-1:0]     r_valid;
    logic [ott_pkg::IdW-1:0] r_next_id;

    // Scan pipeline.
    logic            r_issue;
    logic [AW-1:0]   r_addr;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;
    ott_pkg::t_entry r_q;

    // Scan findings.
    logic            r_best_found;
    logic [AW-1:0]   r_best_idx;
    ott_pkg::t_entry r_best;
    logic            r_free_found;
    logic [AW-1:0]   r_free_idx;
    logic            r_match_found;
    logic [AW-1:0]   r_match_idx;

    // Result registers.
    logic                        r_out_valid;
    logic [1:0]                  r_status;
    logic [ott_pkg::IdW-1:0]     r_rid;
    logic [ott_pkg::ExpW-1:0]    r_rexp;
    logic [ott_pkg::IdW-1:0]     r_rre;
    logic [ott_pkg::SleepW-1:0]  r_sleep;

    logic                        w_ent_vld;
    logic                        w_better;
    logic                        w_due;
    logic [ott_pkg::IdW-1:0]     w_new_id;
    logic                        w_we;
    logic [AW-1:0]               w_wa;
    ott_pkg::t_entry             w_wd;

    // Compare logic for the entry coming out of the memory.
    always_comb begin
        w_ent_vld = r_valid[r_rd_idx];
        w_better  = !r_best_found || (r_q.expire < r_best.expire) ||
                    ((r_q.expire == r_best.expire) && (r_q.id < r_best.id));
        w_due     = r_best_found && (r_best.expire <= r_now);
        w_new_id  = r_next_id + 1'b1;
        o_sts.scan_done = r_rd_vld && (r_rd_idx == LAST);
    end

    // Memory write during the act step: a new timer or a re-armed one.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_free_idx;
        w_wd.expire   = ott_pkg::sat_expiry(r_now, r_period);
        w_wd.period   = r_period;
        w_wd.id       = w_new_id;
        w_wd.periodic = r_per;
        if (i_cmd.act) begin
            case (r_mode)
                ott_pkg::MODE_ADD: begin
                    w_we = r_free_found;
                end
                ott_pkg::MODE_CHECK: begin
                    w_we          = w_due && r_best.periodic;
                    w_wa          = r_best_idx;
                    w_wd.expire   = ott_pkg::sat_expiry(r_now, r_best.period);
                    w_wd.period   = r_best.period;
                    w_wd.periodic = 1'b1;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    // Timer memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (r_issue) r_q <= mem[r_addr];
        if (w_we) mem[w_wa] <= w_wd;
    end

    // Control state, scan and act.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_next_id     <= '0;
            r_issue       <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_best_found  <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;

            if (i_cmd.load) begin
                r_mode        <= i_mode;
                r_now         <= i_now_ms;
                r_period      <= i_period_ms;
                r_per         <= i_periodic;
                r_tid         <= i_target_id;
                r_texp        <= i_target_expire;
                r_addr        <= '0;
                r_issue       <= 1'b1;
                r_best_found  <= 1'b0;
                r_free_found  <= 1'b0;
                r_match_found <= 1'b0;
            end

            // Read addresses go out one per cycle.
            if (r_issue) begin
                r_rd_vld <= 1'b1;
                r_rd_idx <= r_addr;
                if (r_addr == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end

            // Track the earliest entry, the first free slot and the first match.
            if (r_rd_vld) begin
                if (w_ent_vld && w_better) begin
                    r_best_found <= 1'b1;
                    r_best_idx   <= r_rd_idx;
                    r_best       <= r_q;
                end
                if (!w_ent_vld && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
                if (w_ent_vld && !r_match_found && (r_q.id == r_tid) &&
                    (r_q.expire == r_texp)) begin
                    r_match_found <= 1'b1;
                    r_match_idx   <= r_rd_idx;
                end
            end

            // Apply the operation, then restart the scan for the sleep time.
            if (i_cmd.act) begin
                r_addr       <= '0;
                r_issue      <= 1'b1;
                r_best_found <= 1'b0;
                r_status     <= ott_pkg::ST_NONE;
                r_rid        <= '0;
                r_rexp       <= '0;
                r_rre        <= '0;
                case (r_mode)
                    ott_pkg::MODE_ADD: begin
                        if (r_free_found) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_next_id <= w_new_id;
                            r_status  <= ott_pkg::ST_OK;
                            r_rid     <= w_new_id;
                            r_rexp    <= w_wd.expire;
                        end else begin
                            r_status <= ott_pkg::ST_FULL;
                        end
                    end
                    ott_pkg::MODE_DEL: begin
                        if (r_match_found) begin
                            r_valid[r_match_idx] <= 1'b0;
                            r_status <= ott_pkg::ST_OK;
                        end
                    end
                    ott_pkg::MODE_CHECK: begin
                        if (w_due) begin
                            r_status <= ott_pkg::ST_OK;
                            r_rid    <= r_best.id;
                            r_rexp   <= r_best.expire;
                            if (r_best.periodic) begin
                                r_next_id <= w_new_id;
                                r_rre     <= w_new_id;
                            end else begin
                                r_valid[r_best_idx] <= 1'b0;
                            end
                        end
                    end
                    default: begin
                        r_status <= ott_pkg::ST_NONE;
                    end
                endcase
            end

            // Sleep time from the second scan; the result goes out next cycle.
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (!r_best_found) begin
                    r_sleep <= {ott_pkg::SleepW{1'b1}};
                end else if (r_best.expire > r_now) begin
                    r_sleep <= {1'b0, r_best.expire - r_now};
                end else begin
                    r_sleep <= '0;
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_timer_id   = r_rid;
    assign o_expire_ms  = r_rexp;
    assign o_rearmed_id = r_rre;
    assign o_sleep_ms   = r_sleep;

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ott_pkg::ST_FULL)) |-> (&r_valid))
        else $error("table full reported with a free slot");
    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ott_pkg::ST_OK)) |-> (o_timer_id == '0))
        else $error("failed transaction reports an id");

endmodule

/* rtl/core/ordered_timer_table.sv */
// Timer table of CAPACITY entries, searched in order of (expiry, id). A transaction is
// taken at a rising edge where start is high and busy is low. Its single result
// appears in the cycle in which busy drops, so the next transaction can be taken
// from then on. Each transaction makes two passes of one read a cycle through the
// entry memory: one finds the earliest, free or matching entry, and one finds the
// earliest entry left for the sleep time. The result is on the o_ ports for exactly
// one cycle, marked by o_valid, and the receiver cannot stall it. Outside that cycle
// the result ports are not meaningful and may change while the next transaction
// is being processed.
module ordered_timer_table #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_mode,
    input  logic [ott_pkg::ExpW-1:0]          i_now_ms,
    input  logic [ott_pkg::PeriodW-1:0]       i_period_ms,
    input  logic                              i_periodic,
    input  logic [ott_pkg::IdW-1:0]           i_target_id,
    input  logic [ott_pkg::ExpW-1:0]          i_target_expire,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [ott_pkg::IdW-1:0]           o_timer_id,
    output logic [ott_pkg::ExpW-1:0]          o_expire_ms,
    output logic [ott_pkg::IdW-1:0]           o_rearmed_id,
    output logic signed [ott_pkg::SleepW-1:0] o_sleep_ms
);

    ott_pkg::t_cmd w_cmd;
    ott_pkg::t_sts w_sts;

    // Sequencer.
    ott_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // Entry memory, scan and result datapath.
    ott_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_now_ms        (i_now_ms),
        .i_period_ms     (i_period_ms),
        .i_periodic      (i_periodic),
        .i_target_id     (i_target_id),
        .i_target_expire (i_target_expire),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_timer_id      (o_timer_id),
        .o_expire_ms     (o_expire_ms),
        .o_rearmed_id    (o_rearmed_id),
        .o_sleep_ms      (o_sleep_ms)
    );

endmodule
